### rtl/rtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared types and constants for the radar target frame parser.
// ----------------------------------------------------------------------------
package rtf_pkg;

    localparam int TARGET_COUNT_DEF = 3;
    localparam int RECORD_BYTES     = 8;
    localparam int HDR_LEN          = 4;

    localparam logic [7:0] HDR_BYTE0 = 8'hAA;
    localparam logic [7:0] HDR_BYTE1 = 8'hFF;
    localparam logic [7:0] HDR_BYTE2 = 8'h03;
    localparam logic [7:0] HDR_BYTE3 = 8'h00;
    localparam logic [7:0] TAIL_BYTE0 = 8'h55;
    localparam logic [7:0] TAIL_BYTE1 = 8'hCC;

    // mag / 10 == (mag * 52429) >> 19 for every 15-bit magnitude
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Token pushed by the front end when a frame completes
    typedef struct packed {
        logic push;
        logic bank;
    } rtf_tok_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
        logic head_bank;
    } rtf_qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_MUL,
        BK_EMIT
    } rtf_bk_state_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = HDR_BYTE0;
            2'd1:    b = HDR_BYTE1;
            2'd2:    b = HDR_BYTE2;
            2'd3:    b = HDR_BYTE3;
            default: b = HDR_BYTE0;
        endcase
        return b;
    endfunction

endpackage

### rtl/rtf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rtf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_front
// Frame sync: hunts for the header, stores record bytes, checks the tail.
// ----------------------------------------------------------------------------
module rtf_front #(
    parameter int TARGET_COUNT = rtf_pkg::TARGET_COUNT_DEF,
    parameter int ADDR_W       = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  rtf_pkg::rtf_qstat_t q_stat,
    output rtf_pkg::rtf_tok_t  tok,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [7:0]         wr_data
);

    import rtf_pkg::*;

    localparam int DATA_LEN = TARGET_COUNT * RECORD_BYTES;
    localparam int TAIL_POS = HDR_LEN + DATA_LEN;
    localparam int POS_W    = $clog2(TAIL_POS + 2);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic [POS_W-1:0] restart;
    logic [31:0]      wr_off;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    // a stray AA counts as the first header byte
    assign restart = (s_rx_byte == HDR_BYTE0) ? POS_W'(1) : '0;
    assign wr_off  = (bank_reg ? 32'(DATA_LEN) : 32'd0) + 32'(pos_reg) - 32'(HDR_LEN);

    assign wr_addr = wr_off[ADDR_W-1:0];
    assign wr_data = s_rx_byte;

    always_comb begin
        pos_next  = pos_reg;
        bank_next = bank_reg;
        wr_en     = 1'b0;
        tok.push  = 1'b0;
        tok.bank  = bank_reg;
        if (accept) begin
            if (pos_reg < POS_W'(HDR_LEN)) begin
                if (s_rx_byte == hdr_byte(pos_reg[1:0])) begin
                    pos_next = pos_reg + POS_W'(1);
                end else begin
                    pos_next = restart;
                end
            end else if (pos_reg < POS_W'(TAIL_POS)) begin
                wr_en    = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end else if (pos_reg == POS_W'(TAIL_POS)) begin
                pos_next = (s_rx_byte == TAIL_BYTE0) ? pos_reg + POS_W'(1) : restart;
            end else if (s_rx_byte == TAIL_BYTE1) begin
                // hand the finished bank to the back end, fill the other one
                pos_next  = '0;
                tok.push  = 1'b1;
                bank_next = !bank_reg;
            end else begin
                pos_next = restart;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
        end
    end

endmodule

### rtl/rtf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_queue
// Two-entry queue of completed frame banks between front and back ends.
// ----------------------------------------------------------------------------
module rtf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  rtf_pkg::rtf_tok_t  tok,
    input  logic               pop,
    output rtf_pkg::rtf_qstat_t q_stat
);

    import rtf_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] slot_reg;
    logic       do_pop;

    assign do_pop = pop && (cnt_reg != 2'd0);

    always_comb begin
        cnt_next = cnt_reg;
        if (tok.push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!tok.push && do_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (tok.push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok.push) begin
            slot_reg[wr_ptr_reg] <= tok.bank;
        end
    end

    assign q_stat.full      = (cnt_reg == 2'd2);
    assign q_stat.empty     = (cnt_reg == 2'd0);
    assign q_stat.head_bank = slot_reg[rd_ptr_reg];

endmodule

### rtl/rtf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_back
// Target decoder: reads each stored record, scales X and Y, emits results.
// ----------------------------------------------------------------------------
module rtf_back #(
    parameter int TARGET_COUNT = rtf_pkg::TARGET_COUNT_DEF,
    parameter int ADDR_W       = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtf_pkg::rtf_qstat_t q_stat,
    output logic                pop,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [7:0]          rd_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_target_index,
    output logic signed [12:0]  m_x_pos,
    output logic signed [12:0]  m_y_pos,
    output logic signed [15:0]  m_speed,
    output logic [15:0]         m_resolution,
    output logic                m_last_target
);

    import rtf_pkg::*;

    localparam int DATA_LEN = TARGET_COUNT * RECORD_BYTES;
    localparam int TGT_W    = $clog2(TARGET_COUNT + 1);
    localparam int CNT_W    = $clog2(RECORD_BYTES + 1);

    rtf_bk_state_t state_reg, state_next;

    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_pend_reg;
    logic [63:0]       rec_reg;
    logic [30:0]       prod_x_reg, prod_y_reg;
    logic              last_tgt;
    logic              out_free;
    logic              load;
    logic [31:0]       addr_full;
    logic [31:0]       tgt_ext;
    logic [11:0]       qx, qy;
    logic [15:0]       spd_mag;

    logic              m_valid_reg;
    logic [1:0]        idx_reg;
    logic [12:0]       x_reg, y_reg;
    logic [15:0]       spd_reg, res_reg;
    logic              last_reg;

    assign last_tgt = (tgt_reg == TGT_W'(TARGET_COUNT - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign tgt_ext  = 32'(tgt_reg);
    assign addr_full = (q_stat.head_bank ? 32'(DATA_LEN) : 32'd0)
                     + tgt_ext * 32'(RECORD_BYTES) + 32'(cnt_reg);
    assign rd_addr  = addr_full[ADDR_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH: begin
                // last byte lands on this edge
                if (cnt_reg == CNT_W'(RECORD_BYTES) && rd_pend_reg) begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    state_next = last_tgt ? BK_IDLE : BK_FETCH;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        rd_en    = 1'b0;
        pop      = 1'b0;
        load     = 1'b0;
        tgt_next = tgt_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            BK_IDLE: begin
                cnt_next = '0;
                tgt_next = '0;
            end
            BK_FETCH: begin
                if (cnt_reg < CNT_W'(RECORD_BYTES)) begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            BK_MUL: begin
                cnt_next = '0;
            end
            BK_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (last_tgt) begin
                        pop      = 1'b1;
                        tgt_next = '0;
                    end else begin
                        tgt_next = tgt_reg + TGT_W'(1);
                    end
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            tgt_reg     <= '0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tgt_reg     <= tgt_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_en;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    assign qx      = prod_x_reg[DIV10_SHIFT +: 12];
    assign qy      = prod_y_reg[DIV10_SHIFT +: 12];
    assign spd_mag = {1'b0, rec_reg[46:40], rec_reg[39:32]};

    always_ff @(posedge aclk) begin
        // shift bytes in from the top; byte 0 ends up lowest
        if (rd_pend_reg) begin
            rec_reg <= {rd_data, rec_reg[63:8]};
        end
        if (state_reg == BK_MUL) begin
            prod_x_reg <= {rec_reg[14:8], rec_reg[7:0]} * DIV10_MUL;
            prod_y_reg <= {rec_reg[30:24], rec_reg[23:16]} * DIV10_MUL;
        end
        if (load) begin
            idx_reg  <= tgt_ext[1:0];
            x_reg    <= rec_reg[15] ? {1'b0, qx} : 13'd0 - {1'b0, qx};
            y_reg    <= rec_reg[31] ? {1'b0, qy} : 13'd0 - {1'b0, qy};
            spd_reg  <= rec_reg[47] ? spd_mag : 16'd0 - spd_mag;
            res_reg  <= rec_reg[63:48];
            last_reg <= last_tgt;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_target_index = idx_reg;
    assign m_x_pos        = x_reg;
    assign m_y_pos        = y_reg;
    assign m_speed        = spd_reg;
    assign m_resolution   = res_reg;
    assign m_last_target  = last_reg;

endmodule

### rtl/radar_target_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_target_frame_parser
// Frames radar target reports from a serial byte stream and emits one
// decoded word per target record when a frame's tail arrives.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_rx_byte
//  m_       out        m_valid/m_ready    m_target_index, m_x_pos, m_y_pos,
//                                         m_speed, m_resolution, m_last_target
//
// The front end takes one byte per cycle while s_ready is high; record bytes go
// into a two-bank record RAM. A completed frame queues its bank for the back end,
// which decodes one target at a time: 8 byte reads over the single RAM read
// port, multiply, emit. s_ready drops only while both banks are pending.
// Reset (aresetn, synchronous) clears frame sync, the queue and m_valid.
// ----------------------------------------------------------------------------
module radar_target_frame_parser #(
    parameter int TARGET_COUNT = rtf_pkg::TARGET_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_target_index,
    output logic signed [12:0] m_x_pos,
    output logic signed [12:0] m_y_pos,
    output logic signed [15:0] m_speed,
    output logic [15:0]        m_resolution,
    output logic               m_last_target
);

    import rtf_pkg::*;

    localparam int MEM_DEPTH = 2 * TARGET_COUNT * RECORD_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    rtf_tok_t          tok;
    rtf_qstat_t        q_stat;
    logic              pop;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    rtf_front #(
        .TARGET_COUNT(TARGET_COUNT),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .q_stat   (q_stat),
        .tok      (tok),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    rtf_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .tok    (tok),
        .pop    (pop),
        .q_stat (q_stat)
    );

    rtf_ram #(
        .WIDTH(8),
        .DEPTH(MEM_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    rtf_back #(
        .TARGET_COUNT(TARGET_COUNT),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_target_index(m_target_index),
        .m_x_pos       (m_x_pos),
        .m_y_pos       (m_y_pos),
        .m_speed       (m_speed),
        .m_resolution  (m_resolution),
        .m_last_target (m_last_target)
    );

endmodule
